>>> sv/cpf_pkg.sv
// Package for the CRC-32 packet framer: codes, queue entry types, CRC-32 table
// function and framing constants. Depends on nothing; every other file but cpf_if imports it.
`timescale 1ns / 1ps

package cpf_pkg;

   localparam int CPF_QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_UNPACK   = 1'd1;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_DATA  = 1'b1;

   localparam logic [15:0] FRAME_MARKER = 16'h1337;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [2:0]  BIT_TOP      = 3'd7;

   // Last byte index of each item shape
   localparam logic [2:0] HDR_LAST_BYTE  = 3'd7;
   localparam logic [2:0] DATA_LAST_CRC  = 3'd4;
   localparam logic [2:0] DATA_LAST_BARE = 3'd0;

   typedef enum logic {
      KIND_HEADER,
      KIND_DATA
   } kind_type;

   // One framed input word as queued between front and back
   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;     // count for a header, data byte in the low bits
      logic [31:0] crc;       // final (inverted) CRC to append
      logic        with_crc;  // data word closes its packet
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Reflected CRC-32 table entry for one index byte
   function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc_fold_byte(input logic [31:0] c, input logic [7:0] b);
      return crc_table_entry(c[7:0] ^ b) ^ {8'd0, c[31:8]};
   endfunction

   // Running header CRC after the two fixed marker bytes
   localparam logic [31:0] CRC_HDR_PREFIX =
      crc_fold_byte(crc_fold_byte(CRC_INIT, FRAME_MARKER[7:0]), FRAME_MARKER[15:8]);

endpackage

>>> sv/cpf_if.sv
// Valid/ready channel interfaces of the packet framer: request words in and
// response words out. No dependencies.
`timescale 1ns / 1ps

interface cpf_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] payload_count;
   logic [7:0]  data_byte;

   modport source (output valid, action, payload_count, data_byte, input ready);
   modport sink   (input valid, action, payload_count, data_byte, output ready);
endinterface

interface cpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_value;
   logic       run_last;
   logic       packet_end;

   modport source (output valid, out_value, run_last, packet_end, input ready);
   modport sink   (input valid, out_value, run_last, packet_end, output ready);
endinterface

>>> sv/cpf_queue.sv
// Short word queue between the framer front and back.
// Depends on cpf_pkg for the entry and status types.
`timescale 1ns / 1ps

module cpf_queue import cpf_pkg::*; #(
   parameter int DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/cpf_front.sv
// Framer front: accepts request words, tracks the open packet and its running
// CRC-32, and queues one entry per word that yields output. Depends on cpf_pkg, cpf_if.
`timescale 1ns / 1ps

module cpf_front import cpf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cpf_req_if.sink          req_bus,
   input  logic             frame_enable,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_entry
);

   logic [31:0] crc_ff, crc_in;
   logic [15:0] left_ff, left_in;
   logic        open_ff, open_in;
   logic        accept;
   logic [31:0] crc_next;
   logic [15:0] left_next;
   logic [31:0] hdr_crc;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign crc_next  = crc_fold_byte(crc_ff, req_bus.data_byte);
   assign left_next = left_ff - 16'd1;
   assign hdr_crc   = crc_fold_byte(crc_fold_byte(CRC_HDR_PREFIX, req_bus.payload_count[7:0]),
                                    req_bus.payload_count[15:8]) ^ CRC_INIT;

   always_comb begin
      crc_in              = crc_ff;
      left_in             = left_ff;
      open_in             = open_ff;
      push                = 1'b0;
      push_entry.kind     = KIND_DATA;
      push_entry.value    = {8'd0, req_bus.data_byte};
      push_entry.crc      = crc_next ^ CRC_INIT;
      push_entry.with_crc = 1'b0;
      if (accept) begin
         if (req_bus.action == ACTION_START) begin
            // Any open packet is dropped without its CRC
            crc_in  = CRC_INIT;
            left_in = frame_enable ? req_bus.payload_count : 16'd0;
            open_in = frame_enable && (req_bus.payload_count != 16'd0);
            push    = frame_enable;
            push_entry.kind  = KIND_HEADER;
            push_entry.value = req_bus.payload_count;
            push_entry.crc   = hdr_crc;
         end else begin
            push = 1'b1;
            if (open_ff) begin
               if (left_next == 16'd0) begin
                  push_entry.with_crc = 1'b1;
                  crc_in  = CRC_INIT;
                  open_in = 1'b0;
               end else begin
                  crc_in = crc_next;
               end
               left_in = left_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> sv/cpf_back.sv
// Framer back: expands queued entries into bytes or single bits and drives the
// registered response channel. Depends on cpf_pkg, cpf_if.
`timescale 1ns / 1ps

module cpf_back import cpf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             bit_unpack,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   cpf_rsp_if.source        rsp_bus
);

   entry_type   cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  value_ff, value_in;
   logic        run_last_ff, run_last_in;
   logic        pkt_end_ff, pkt_end_in;

   logic        out_free, emit, byte_last, bit_last, item_done, load;
   logic [2:0]  last_byte;
   logic [7:0]  cur_byte;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = cur_valid_ff && out_free;

   always_comb begin
      if (cur_ff.kind == KIND_HEADER) begin
         last_byte = HDR_LAST_BYTE;
      end else begin
         last_byte = cur_ff.with_crc ? DATA_LAST_CRC : DATA_LAST_BARE;
      end
   end

   // Byte lane of the current entry, multi-byte fields low byte first
   always_comb begin
      cur_byte = 8'd0;
      if (cur_ff.kind == KIND_HEADER) begin
         case (byte_idx_ff)
            3'd0:    cur_byte = FRAME_MARKER[7:0];
            3'd1:    cur_byte = FRAME_MARKER[15:8];
            3'd2:    cur_byte = cur_ff.value[7:0];
            3'd3:    cur_byte = cur_ff.value[15:8];
            3'd4:    cur_byte = cur_ff.crc[7:0];
            3'd5:    cur_byte = cur_ff.crc[15:8];
            3'd6:    cur_byte = cur_ff.crc[23:16];
            default: cur_byte = cur_ff.crc[31:24];
         endcase
      end else begin
         case (byte_idx_ff)
            3'd0:    cur_byte = cur_ff.value[7:0];
            3'd1:    cur_byte = cur_ff.crc[7:0];
            3'd2:    cur_byte = cur_ff.crc[15:8];
            3'd3:    cur_byte = cur_ff.crc[23:16];
            default: cur_byte = cur_ff.crc[31:24];
         endcase
      end
   end

   assign byte_last = (byte_idx_ff == last_byte);
   assign bit_last  = !bit_unpack || (bit_idx_ff == BIT_TOP);
   assign item_done = emit && byte_last && bit_last;
   assign load      = !cur_valid_ff || item_done;
   assign pop       = load && !q_status.empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      byte_idx_in  = byte_idx_ff;
      bit_idx_in   = bit_idx_ff;
      if (load) begin
         cur_in       = head;
         cur_valid_in = !q_status.empty;
         byte_idx_in  = '0;
         bit_idx_in   = '0;
      end else if (emit) begin
         if (bit_last) begin
            bit_idx_in  = '0;
            byte_idx_in = byte_idx_ff + 3'd1;
         end else begin
            bit_idx_in = bit_idx_ff + 3'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      value_in     = value_ff;
      run_last_in  = run_last_ff;
      pkt_end_in   = pkt_end_ff;
      if (emit) begin
         value_in    = bit_unpack ? {7'd0, cur_byte[BIT_TOP - bit_idx_ff]} : cur_byte;
         run_last_in = byte_last && bit_last;
         pkt_end_in  = byte_last && bit_last && (cur_ff.kind == KIND_DATA) && cur_ff.with_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         byte_idx_ff  <= '0;
         bit_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         byte_idx_ff  <= byte_idx_in;
         bit_idx_ff   <= bit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      value_ff    <= value_in;
      run_last_ff <= run_last_in;
      pkt_end_ff  <= pkt_end_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_value  = value_ff;
   assign rsp_bus.run_last   = run_last_ff;
   assign rsp_bus.packet_end = pkt_end_ff;

endmodule

>>> sv/crc32_packet_framer.sv
// The first response word of a request word passes the queue, the back's entry register and
// the output register. Throughput: one response word per cycle from the back serializer while
// the receiver is ready. A word yields none for a start with framing off, 1, 5 or 8 in byte
// mode and eight times that in bit mode; the front accepts a word each cycle while the queue
// has room. Reset (synchronous, active high) empties queue and output, closes any packet, sets
// the CRC to all ones, framing on and bit mode off; no clearing pass.
`timescale 1ns / 1ps

module crc32_packet_framer import cpf_pkg::*; #(
   parameter int QUEUE_DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   cpf_req_if.sink                req_bus,
   cpf_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers; the user must write them only while the framer is idle, the block does not enforce it
   logic frame_enable_ff, frame_enable_in;
   logic bit_unpack_ff, bit_unpack_in;

   always_comb begin
      frame_enable_in = frame_enable_ff;
      bit_unpack_in   = bit_unpack_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_ENABLE: frame_enable_in = csr_write_data[0];
            CSR_BIT_UNPACK:   bit_unpack_in   = csr_write_data[0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_enable_ff <= 1'b1;
         bit_unpack_ff   <= 1'b0;
      end else begin
         frame_enable_ff <= frame_enable_in;
         bit_unpack_ff   <= bit_unpack_in;
      end
   end

   // Front: classify words, advance packet state, queue what must be sent
   logic             q_push;
   logic             q_pop;
   entry_type        q_push_entry;
   entry_type        q_head;
   queue_status_type q_status;

   cpf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .frame_enable (frame_enable_ff),
      .q_status     (q_status),
      .push         (q_push),
      .push_entry   (q_push_entry)
   );

   // Queue: lets the front keep taking words while the back drains a long one
   cpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // Back: serialize each entry into bytes or bits behind the output register
   cpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .bit_unpack (bit_unpack_ff),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

>>> sv/cpf_checker.sv
// Port-level checks for the packet framer, attached to the top level by bind.
// Depends on cpf_pkg for the configuration port widths.
`timescale 1ns / 1ps

module cpf_checker import cpf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [7:0]             rsp_out_value,
   input logic                   rsp_run_last,
   input logic                   rsp_packet_end,
   input logic                   csr_wr_en,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic seen_req_ff, seen_req_in;

   assign seen_req_in = seen_req_ff || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_req_ff <= 1'b0;
      end else begin
         seen_req_ff <= seen_req_in;
      end
   end

   // Reset empties the output register
   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // No response before any word has been taken since reset
   a_no_invented_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_req_ff)
      else $error("response without an accepted request");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_out_value) && $stable(rsp_run_last) && $stable(rsp_packet_end))
      else $error("response payload changed while stalled");

   // A register write carries a known index and value
   a_csr_write_known: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !$isunknown({csr_index, csr_write_data}))
      else $error("register write with unknown index or data");

endmodule

bind crc32_packet_framer cpf_checker u_cpf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_out_value  (rsp_bus.out_value),
   .rsp_run_last   (rsp_bus.run_last),
   .rsp_packet_end (rsp_bus.packet_end),
   .csr_wr_en      (csr_wr_en),
   .csr_index      (csr_index),
   .csr_write_data (csr_write_data)
);
